/* rtl/sti_pkg.sv */
// ----------------------------------------------------------------------------
// sti_pkg: shared types and codes of the sorted interpolation table
// Transaction payloads, function and status codes, cell hit record, FSM states.
// ----------------------------------------------------------------------------
package sti_pkg;

  // product and divisor widths of the interpolation step
  localparam int unsigned NumW = 34;
  localparam int unsigned DenW = 17;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_QUERY  = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_EXACT  = 3'd0,
    ST_INTERP = 3'd1,
    ST_RANGE  = 3'd2,
    ST_STORED = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    HIT_NONE,
    HIT_EXACT,
    HIT_INTERP
  } hit_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_FIN
  } fsm_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] angle;
    logic signed [15:0] lift_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] lift_out;
    logic [2:0]         status;
    logic [6:0]         entry_count;
  } out_t;

  // bracket found by the scan chain
  typedef struct packed {
    hit_e               kind;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
  } hit_t;

  // broadcast to every cell
  typedef struct packed {
    logic               ins_en;
    logic signed [15:0] key;
    logic signed [15:0] lift;
  } cell_ctl_t;

endpackage

/* rtl/sorted_table_linear_interpolation.sv */
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolation: sorted (angle, lift) table with lookup
// Insert, clear and piecewise linear query over a chain of table cells.
// ----------------------------------------------------------------------------
// Each transaction is handled alone. Insert, clear and unused codes pass
// through the execute and finish states. A query that hits an angle or misses
// the table passes through execute, scan, multiply and finish, since the
// bracket record ripples one cell per cycle down the DEPTH-cell chain; an
// interpolated query adds the divider start state, the bit-serial divide of
// its 34 steps and taking the quotient before finish.
// A result waits in the output register while the next transaction is taken.
module sorted_table_linear_interpolation #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sti_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sti_pkg::out_t out_data_o
);
  import sti_pkg::*;

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SCW = $clog2(DEPTH);

  fsm_e           state_q, state_d;
  in_t            item_q;
  logic [CW-1:0]  count_q, count_d;
  logic [SCW-1:0] scan_q;
  out_t           res_q, res_d, out_q;
  logic           out_valid_q;
  hit_t           hit_q;
  logic signed [NumW-1:0] prod_q;
  logic           out_free, ins_en, div_start, div_busy;
  logic [NumW-1:0] div_quo, mag;
  logic signed [16:0] dx, dy;
  logic signed [17:0] qs, ysum;
  cell_ctl_t      ctl;

  logic signed [15:0] ang_w [DEPTH+1];
  logic signed [15:0] lft_w [DEPTH+1];
  logic               gt_w  [DEPTH+1];
  logic               ge_w  [DEPTH+1];
  hit_t               hit_w [DEPTH+1];

  assign out_free = !out_valid_q || !out_stall_i;

  // cell chain, index 0 is the empty left boundary
  assign ang_w[0] = '0;
  assign lft_w[0] = '0;
  assign gt_w[0]  = 1'b0;
  assign ge_w[0]  = 1'b0;
  assign hit_w[0] = '{kind: HIT_NONE, default: '0};

  assign ctl.ins_en = ins_en;
  assign ctl.key    = item_q.angle;
  assign ctl.lift   = item_q.lift_in;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sti_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .count_i      (count_q),
      .left_angle_i (ang_w[g]),
      .left_lift_i  (lft_w[g]),
      .left_gt_i    (gt_w[g]),
      .left_ge_i    (ge_w[g]),
      .left_hit_i   (hit_w[g]),
      .angle_o      (ang_w[g+1]),
      .lift_o       (lft_w[g+1]),
      .gt_o         (gt_w[g+1]),
      .ge_o         (ge_w[g+1]),
      .hit_o        (hit_w[g+1])
    );
  end

  // interpolation arithmetic
  assign dx   = 17'(item_q.angle) - 17'(hit_w[DEPTH].x0);
  assign dy   = 17'(hit_w[DEPTH].y1) - 17'(hit_w[DEPTH].y0);
  assign mag  = prod_q[NumW-1] ? NumW'(-prod_q) : NumW'(prod_q);
  assign qs   = prod_q[NumW-1] ? -$signed({1'b0, div_quo[16:0]})
                               : $signed({1'b0, div_quo[16:0]});
  assign ysum = 18'(hit_q.y0) + qs;

  sti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag),
    .den_i   (DenW'(17'(hit_q.x1) - 17'(hit_q.x0))),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_EXEC;
      S_EXEC:   state_d = (func_e'(item_q.func) == FN_QUERY) ? S_SCAN : S_FIN;
      S_SCAN:   if (scan_q == SCW'(DEPTH - 1)) state_d = S_MUL;
      S_MUL:    state_d = (hit_w[DEPTH].kind == HIT_INTERP) ? S_DSTART : S_FIN;
      S_DSTART: state_d = S_DIV;
      S_DIV:    if (!div_busy) state_d = S_FIN;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ins_en    = 1'b0;
    div_start = 1'b0;
    count_d   = count_q;
    res_d     = res_q;
    unique case (state_q)
      S_EXEC: begin
        res_d.lift_out = '0;
        res_d.status   = ST_STORED;
        case (func_e'(item_q.func))
          FN_INSERT: begin
            if (count_q >= CW'(DEPTH)) begin
              res_d.status = ST_FULL;
            end else begin
              ins_en  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          FN_CLEAR: count_d = '0;
          FN_QUERY: res_d.status = ST_RANGE;
          default:  res_d.status = ST_RANGE;
        endcase
        res_d.entry_count = 7'(count_d);
      end
      S_MUL: begin
        if (hit_w[DEPTH].kind == HIT_EXACT) begin
          res_d.lift_out = hit_w[DEPTH].y1;
          res_d.status   = ST_EXACT;
        end
      end
      S_DSTART: div_start = 1'b1;
      S_DIV: begin
        if (!div_busy) begin
          res_d.lift_out = ysum[15:0];
          res_d.status   = ST_INTERP;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= (state_q == S_SCAN) ? scan_q + 1'b1 : '0;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == S_IDLE && in_valid_i) item_q <= in_data_i;
    if (state_q == S_MUL) begin
      hit_q  <= hit_w[DEPTH];
      prod_q <= dx * dy;
    end
    if (state_q == S_FIN && out_free) out_q <= res_q;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/sti_cell.sv */
// ----------------------------------------------------------------------------
// sti_cell: one table slot
// Holds one pair, shifts right on a sorted insert and passes the bracket
// record to its right neighbor every cycle.
// ----------------------------------------------------------------------------
module sti_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic               clk_i,
  input  sti_pkg::cell_ctl_t ctl_i,
  input  logic [CW-1:0]      count_i,
  input  logic signed [15:0] left_angle_i,
  input  logic signed [15:0] left_lift_i,
  input  logic               left_gt_i,
  input  logic               left_ge_i,
  input  sti_pkg::hit_t      left_hit_i,
  output logic signed [15:0] angle_o,
  output logic signed [15:0] lift_o,
  output logic               gt_o,
  output logic               ge_o,
  output sti_pkg::hit_t      hit_o
);
  import sti_pkg::*;

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic signed [15:0] angle_q, lift_q;
  hit_t               hit_q, hit_d;
  logic               occ, sel;

  assign occ  = IdxC < count_i;
  assign gt_o = occ && (angle_q > ctl_i.key);
  assign ge_o = occ && (angle_q >= ctl_i.key);
  assign sel  = ge_o && !left_ge_i;

  // sorted insert: take the left pair, the new pair, or keep
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins_en && (IdxC <= count_i)) begin
      if (left_gt_i) begin
        angle_q <= left_angle_i;
        lift_q  <= left_lift_i;
      end else if (gt_o || (IdxC == count_i)) begin
        angle_q <= ctl_i.key;
        lift_q  <= ctl_i.lift;
      end
    end
  end

  // bracket record: this cell holds the first angle >= key
  always_comb begin
    hit_d = left_hit_i;
    if (sel) begin
      hit_d.x0 = left_angle_i;
      hit_d.y0 = left_lift_i;
      hit_d.x1 = angle_q;
      hit_d.y1 = lift_q;
      if (angle_q == ctl_i.key) begin
        hit_d.kind = HIT_EXACT;
      end else if (IDX > 0) begin
        hit_d.kind = HIT_INTERP;
      end else begin
        hit_d.kind = HIT_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign angle_o = angle_q;
  assign lift_o  = lift_q;
  assign hit_o   = hit_q;

endmodule

/* rtl/sti_div.sv */
// ----------------------------------------------------------------------------
// sti_div: unsigned restoring divider
// One quotient bit per cycle, NumW quotient bits per division.
// ----------------------------------------------------------------------------
module sti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sti_pkg::NumW-1:0]    num_i,
  input  logic [sti_pkg::DenW-1:0]    den_i,
  output logic                        busy_o,
  output logic [sti_pkg::NumW-1:0]    quo_o
);
  import sti_pkg::*;

  localparam int unsigned CntW = $clog2(NumW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   rem_q, rem_sh;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] den_q;
  logic            take;

  assign rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign take   = rem_sh >= {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[NumW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/sti_checker.sv */
// ----------------------------------------------------------------------------
// sti_checker: port-level checks of the sorted interpolation table
// Watches the top-level transactions and is bound to the top level.
// ----------------------------------------------------------------------------
module sti_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sti_pkg::out_t out_data_o
);
  import sti_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one transaction at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // status code is a defined one
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_FULL)
    else $error("bad status code");

  // only lookups carry a lift
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_RANGE || out_data_o.status == ST_STORED ||
                    out_data_o.status == ST_FULL) |-> out_data_o.lift_out == '0)
    else $error("nonzero lift on a non-lookup result");

endmodule

bind sorted_table_linear_interpolation sti_checker u_sti_checker (.*);
